// ----- rtl/icaf_pkg.sv -----
`default_nettype none
package icaf_pkg;

    localparam int CNT_W       = 5;
    localparam int SQRT_ITER   = 29;
    localparam int SAMPLE_W    = 116;

    localparam logic [2:0] REG_ACC_OFF_X  = 3'd0;
    localparam logic [2:0] REG_ACC_OFF_Y  = 3'd1;
    localparam logic [2:0] REG_ACC_OFF_Z  = 3'd2;
    localparam logic [2:0] REG_RATE_OFF_X = 3'd3;
    localparam logic [2:0] REG_RATE_OFF_Y = 3'd4;
    localparam logic [2:0] REG_RATE_OFF_Z = 3'd5;
    localparam logic [2:0] REG_RANGE_SEL  = 3'd6;
    localparam logic [2:0] REG_BLEND_WT   = 3'd7;

    localparam logic [2:0]  RANGE_SEL_RST = 3'd1;
    localparam logic [16:0] BLEND_WT_RST  = 17'd64225;
    localparam logic [16:0] ALPHA_ONE     = 17'd65536;
    localparam logic [2:0]  RANGE_SEL_MAX = 3'd4;

    localparam logic signed [25:0] ANG_90  = 26'sd5898240;
    localparam logic signed [34:0] ANG_180 = 35'sd11796480;
    localparam logic signed [34:0] ANG_360 = 35'sd23592960;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_G1000,
        OP_MUL_DT,
        OP_INC,
        OP_MUL_SQ,
        OP_SQ_HOLD,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_CORDIC_SAVE,
        OP_MUL_GYRO,
        OP_HOLD_GYRO,
        OP_MUL_ACC,
        OP_BLEND,
        OP_YAW
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    // atan(2^-i) in Q16 degrees
    function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
        logic [21:0] v;
        begin
            unique case (i)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/icaf_ctrl.sv -----
`default_nettype none
module icaf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output icaf_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_GX, S_GDT, S_INC, S_SQA, S_SQH, S_SQB, S_SQI, S_SQRT,
        S_CI, S_CS, S_CV, S_WAIT, S_BG, S_BH, S_BA, S_BL, S_YAW
    } t_state;

    t_state                       r_state;
    logic [1:0]                   r_axis;
    logic [icaf_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.idx = icaf_pkg::CNT_W'(r_axis);
        unique case (r_state)
            S_IDLE: o_cmd.op = i_in_valid ? icaf_pkg::OP_LOAD : icaf_pkg::OP_NOP;
            S_GX:   o_cmd.op = icaf_pkg::OP_MUL_G1000;
            S_GDT:  o_cmd.op = icaf_pkg::OP_MUL_DT;
            S_INC:  o_cmd.op = icaf_pkg::OP_INC;
            S_SQA:  o_cmd.op = icaf_pkg::OP_MUL_SQ;
            S_SQH:  o_cmd.op = icaf_pkg::OP_SQ_HOLD;
            S_SQB:  o_cmd.op = icaf_pkg::OP_MUL_SQ;
            S_SQI:  o_cmd.op = icaf_pkg::OP_SQRT_INIT;
            S_SQRT: o_cmd.op = icaf_pkg::OP_SQRT_STEP;
            S_CI:   o_cmd.op = icaf_pkg::OP_CORDIC_INIT;
            S_CS: begin
                o_cmd.op  = icaf_pkg::OP_CORDIC_STEP;
                o_cmd.idx = r_cnt;
            end
            S_CV:   o_cmd.op = icaf_pkg::OP_CORDIC_SAVE;
            S_WAIT: o_cmd.op = icaf_pkg::OP_NOP;
            S_BG:   o_cmd.op = icaf_pkg::OP_MUL_GYRO;
            S_BH:   o_cmd.op = icaf_pkg::OP_HOLD_GYRO;
            S_BA:   o_cmd.op = icaf_pkg::OP_MUL_ACC;
            S_BL:   o_cmd.op = icaf_pkg::OP_BLEND;
            S_YAW:  o_cmd.op = icaf_pkg::OP_YAW;
            default: o_cmd.op = icaf_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_axis  <= 2'd0;
                        r_state <= S_GX;
                    end
                end
                S_GX:  r_state <= S_GDT;
                S_GDT: r_state <= S_INC;
                S_INC: begin
                    if (r_axis == 2'd2) begin
                        r_axis  <= 2'd0;
                        r_state <= S_SQA;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_GX;
                    end
                end
                S_SQA: r_state <= S_SQH;
                S_SQH: begin
                    r_axis  <= 2'd1;
                    r_state <= S_SQB;
                end
                S_SQB: r_state <= S_SQI;
                S_SQI: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == icaf_pkg::CNT_W'(icaf_pkg::SQRT_ITER - 1)) begin
                        r_axis  <= 2'd0;
                        r_state <= S_CI;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CI: begin
                    r_cnt   <= '0;
                    r_state <= S_CS;
                end
                S_CS: begin
                    if (r_cnt == icaf_pkg::CNT_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_CV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CV: begin
                    if (r_axis == 2'd1) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_axis  <= 2'd1;
                        r_state <= S_CI;
                    end
                end
                // angle state doubles as the output register
                S_WAIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_axis  <= 2'd0;
                        r_state <= S_BG;
                    end
                end
                S_BG: r_state <= S_BH;
                S_BH: r_state <= S_BA;
                S_BA: r_state <= S_BL;
                S_BL: begin
                    if (r_axis == 2'd1) begin
                        r_axis  <= 2'd2;
                        r_state <= S_YAW;
                    end else begin
                        r_axis  <= 2'd1;
                        r_state <= S_BG;
                    end
                end
                S_YAW: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/icaf_dp.sv -----
`default_nettype none
module icaf_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [2:0]                       i_cfg_idx,
    input  wire  [23:0]                      i_cfg_data,
    input  wire  [icaf_pkg::SAMPLE_W-1:0]    i_sample,
    input  icaf_pkg::t_cmd                   i_cmd,
    output logic [95:0]                      o_result
);

    // configuration
    logic signed [23:0] r_acc_off [3];
    logic signed [23:0] r_rate_off [3];
    logic [2:0]         r_sel;
    logic [16:0]        r_wt;

    // working registers
    logic signed [25:0] r_acc [3];
    logic signed [25:0] r_g [3];
    logic [19:0]        r_dt;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_inc [3];
    logic [48:0]        r_sq;
    logic [57:0]        r_rem;
    logic [57:0]        r_res;
    logic [57:0]        r_bit;
    logic signed [47:0] r_cx;
    logic signed [47:0] r_cy;
    logic signed [25:0] r_cz;
    logic               r_czero;
    logic signed [25:0] r_acc_ang [2];
    logic signed [49:0] r_hold;
    logic signed [31:0] r_ang [3];

    logic [1:0]         axis;
    logic signed [25:0] raw_sx [6];
    logic signed [25:0] corr [6];
    logic signed [36:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [63:0] product;
    logic [2:0]         sel_c;
    logic [5:0]         sh;
    logic signed [63:0] inc_sum;
    logic signed [63:0] inc_val;
    logic [16:0]        alpha;
    logic signed [33:0] gsum;
    logic [57:0]        trial;
    logic signed [30:0] ci_y;
    logic signed [30:0] ci_x;
    logic signed [47:0] sy;
    logic signed [47:0] sx;
    logic signed [47:0] xs;
    logic signed [47:0] ys;
    logic signed [25:0] at;
    logic signed [63:0] bsum;
    logic signed [63:0] bval;
    logic signed [34:0] yw;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647) begin
                r = 32'sh7fffffff;
            end else if (v < -64'sd2147483648) begin
                r = 32'sh80000000;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    assign axis = i_cmd.idx[1:0];

    // bias removal, y and z negated
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            raw_sx[k] = {{2{i_sample[16*k+15]}}, i_sample[16*k +: 16], 8'b0};
        end
        for (int k = 0; k < 3; k++) begin
            corr[k]   = raw_sx[k] - {{2{r_acc_off[k][23]}}, r_acc_off[k]};
            corr[k+3] = raw_sx[k+3] - {{2{r_rate_off[k][23]}}, r_rate_off[k]};
        end
    end

    assign sel_c   = (r_sel > icaf_pkg::RANGE_SEL_MAX) ? icaf_pkg::RANGE_SEL_MAX : r_sel;
    assign sh      = 6'd26 + {3'b0, sel_c};
    assign inc_sum = r_prod + (64'sd1 <<< (sh - 6'd1));
    assign inc_val = inc_sum >>> sh;
    assign alpha   = (r_wt > icaf_pkg::ALPHA_ONE) ? icaf_pkg::ALPHA_ONE : r_wt;
    assign gsum    = {{2{r_ang[axis][31]}}, r_ang[axis]} + {{2{r_inc[axis][31]}}, r_inc[axis]};

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            icaf_pkg::OP_MUL_G1000: begin
                mul_a = {{11{r_g[axis][25]}}, r_g[axis]};
                mul_b = 27'sd1000;
            end
            icaf_pkg::OP_MUL_DT: begin
                mul_a = r_prod[36:0];
                mul_b = {7'b0, r_dt};
            end
            icaf_pkg::OP_MUL_SQ: begin
                mul_a = {{11{r_acc[axis+2'd1][25]}}, r_acc[axis+2'd1]};
                mul_b = {r_acc[axis+2'd1][25], r_acc[axis+2'd1]};
            end
            icaf_pkg::OP_MUL_GYRO: begin
                mul_a = {{3{gsum[33]}}, gsum};
                mul_b = {10'b0, alpha};
            end
            icaf_pkg::OP_MUL_ACC: begin
                mul_a = {{11{r_acc_ang[axis[0]][25]}}, r_acc_ang[axis[0]]};
                mul_b = {10'b0, 17'(icaf_pkg::ALPHA_ONE - alpha)};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign product = mul_a * mul_b;

    assign trial = r_res + r_bit;

    // vectoring start: roll from (ay, az), pitch from (-16 ax, magnitude)
    always_comb begin
        if (axis[0]) begin
            ci_y = -{r_acc[0][25], r_acc[0], 4'b0};
            ci_x = {1'b0, r_res[29:0]};
        end else begin
            ci_y = {{5{r_acc[1][25]}}, r_acc[1]};
            ci_x = {{5{r_acc[2][25]}}, r_acc[2]};
        end
        sy = {ci_y[30], ci_y, 16'b0};
        sx = {ci_x[30], ci_x, 16'b0};
    end

    assign xs = r_cx >>> i_cmd.idx;
    assign ys = r_cy >>> i_cmd.idx;
    assign at = $signed({4'b0, icaf_pkg::atan_q16(i_cmd.idx)});

    assign bsum = {{14{r_hold[49]}}, r_hold} + r_prod + 64'sd32768;
    assign bval = bsum >>> 16;

    always_comb begin
        yw = {{3{r_ang[2][31]}}, r_ang[2]} + {{3{r_inc[2][31]}}, r_inc[2]};
        if (yw > icaf_pkg::ANG_180) begin
            yw = yw - icaf_pkg::ANG_360;
        end
        if (yw < -icaf_pkg::ANG_180) begin
            yw = yw + icaf_pkg::ANG_360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_acc_off[k]  <= '0;
                r_rate_off[k] <= '0;
                r_ang[k]      <= '0;
            end
            r_sel <= icaf_pkg::RANGE_SEL_RST;
            r_wt  <= icaf_pkg::BLEND_WT_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    icaf_pkg::REG_ACC_OFF_X:  r_acc_off[0]  <= i_cfg_data;
                    icaf_pkg::REG_ACC_OFF_Y:  r_acc_off[1]  <= i_cfg_data;
                    icaf_pkg::REG_ACC_OFF_Z:  r_acc_off[2]  <= i_cfg_data;
                    icaf_pkg::REG_RATE_OFF_X: r_rate_off[0] <= i_cfg_data;
                    icaf_pkg::REG_RATE_OFF_Y: r_rate_off[1] <= i_cfg_data;
                    icaf_pkg::REG_RATE_OFF_Z: r_rate_off[2] <= i_cfg_data;
                    icaf_pkg::REG_RANGE_SEL:  r_sel         <= i_cfg_data[2:0];
                    icaf_pkg::REG_BLEND_WT:   r_wt          <= i_cfg_data[16:0];
                    default:                  r_wt          <= r_wt;
                endcase
            end
            if (i_cmd.op == icaf_pkg::OP_BLEND) begin
                r_ang[axis] <= sat32(bval);
            end else if (i_cmd.op == icaf_pkg::OP_YAW) begin
                r_ang[2] <= sat32({{29{yw[34]}}, yw});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            icaf_pkg::OP_LOAD: begin
                r_acc[0] <= corr[0];
                r_acc[1] <= -corr[1];
                r_acc[2] <= -corr[2];
                r_g[0]   <= corr[3];
                r_g[1]   <= -corr[4];
                r_g[2]   <= -corr[5];
                r_dt     <= i_sample[115:96];
            end
            icaf_pkg::OP_MUL_G1000, icaf_pkg::OP_MUL_DT, icaf_pkg::OP_MUL_SQ,
            icaf_pkg::OP_MUL_GYRO, icaf_pkg::OP_MUL_ACC: begin
                r_prod <= product;
            end
            icaf_pkg::OP_INC: r_inc[axis] <= inc_val[31:0];
            icaf_pkg::OP_SQ_HOLD: r_sq <= r_prod[48:0];
            icaf_pkg::OP_SQRT_INIT: begin
                r_rem <= {(50'(r_sq) + 50'(r_prod[48:0])), 8'b0};
                r_res <= '0;
                r_bit <= 58'd1 << 56;
            end
            icaf_pkg::OP_SQRT_STEP: begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            icaf_pkg::OP_CORDIC_INIT: begin
                r_czero <= (ci_x == 31'sd0) && (ci_y == 31'sd0);
                if (sx < 48'sd0) begin
                    if (sy >= 48'sd0) begin
                        r_cx <= sy;
                        r_cy <= -sx;
                        r_cz <= icaf_pkg::ANG_90;
                    end else begin
                        r_cx <= -sy;
                        r_cy <= sx;
                        r_cz <= -icaf_pkg::ANG_90;
                    end
                end else begin
                    r_cx <= sx;
                    r_cy <= sy;
                    r_cz <= '0;
                end
            end
            icaf_pkg::OP_CORDIC_STEP: begin
                if (r_cy > 48'sd0) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + at;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - at;
                end
            end
            icaf_pkg::OP_CORDIC_SAVE: r_acc_ang[axis[0]] <= r_czero ? 26'sd0 : r_cz;
            icaf_pkg::OP_HOLD_GYRO: r_hold <= r_prod[49:0];
            default: r_hold <= r_hold;
        endcase
    end

    assign o_result = {r_ang[2], r_ang[1], r_ang[0]};

endmodule
`default_nettype wire

// ----- rtl/imu_complementary_attitude_filter.sv -----
`default_nettype none
// Roll/pitch complementary filter and yaw integrator for raw accelerometer and
// gyro samples. One sample is taken at a time and yields one angle item;
// the next sample is accepted only after the previous one has run through
// the sequenced datapath: three gyro increments on one shared multiplier,
// a 29-step bit-serial square root and two CORDIC vectoring passes. A
// finished item waits in the angle state registers while the next sample is
// processed; the filter stalls just before updating the angles until that
// item is taken. Angles are Q15.16 degrees. Configuration must be written
// only while idle; the block itself does not enforce this.
module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_step
    input  wire  [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // roll_deg, pitch_deg, yaw_deg
    output logic [95:0]  m_axis_tdata,
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_idx,
    input  wire  [23:0]  i_cfg_data
);

    icaf_pkg::t_cmd cmd;

    icaf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    icaf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata[icaf_pkg::SAMPLE_W-1:0]),
        .i_cmd      (cmd),
        .o_result   (m_axis_tdata)
    );

endmodule
`default_nettype wire
